>>> hw/rtl/grfps_pkg.sv
package grfps_pkg;

   // Width of every input operand.
   localparam int unsigned OP_W = 31;
   // Width of a normalization count (0 to 30).
   localparam int unsigned CNT_W = 5;
   // Divisor width of the shared divider: at most the top 15 bits of s.
   localparam int unsigned DEN_W = 15;
   // Quotient bits the divider produces, one per cycle.
   localparam int unsigned QUOT_W = 17;
   // Number of halving steps in the normalizer (shifts of 16, 8, 4, 2, 1).
   localparam int unsigned NORM_STEPS = 5;
   // Upper bound on the downward quotient corrections.
   localparam int unsigned CORR_MAX = 8;
   // Count at which s is below 2^15 and the direct division applies.
   localparam logic [CNT_W-1:0] SMALL_SUM_CNT = 5'd16;

   typedef logic [OP_W-1:0]   operand_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [DEN_W-1:0]  divisor_type;
   typedef logic [QUOT_W-1:0] quotient_type;

endpackage

>>> hw/rtl/grfps_div.sv
module grfps_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  grfps_pkg::operand_type dividend,
   input  grfps_pkg::divisor_type divisor,
   output logic                   done,
   output grfps_pkg::quotient_type quotient,
   output grfps_pkg::divisor_type remainder
);
   import grfps_pkg::*;

   // Restoring divider, one quotient bit per cycle. The caller guarantees that
   // the quotient fits in QUOT_W bits, so the upper dividend bits start below
   // the divisor.
   logic              busy_ff;
   logic              done_ff;
   logic [4:0]        step_ff;
   divisor_type       rem_ff;
   divisor_type       den_ff;
   quotient_type      lo_ff;
   logic [DEN_W:0]    trial;
   logic              take;

   assign trial = {rem_ff, lo_ff[QUOT_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= DEN_W'(dividend[OP_W-1:QUOT_W]);
            lo_ff   <= dividend[QUOT_W-1:0];
            den_ff  <= divisor;
         end else if (busy_ff) begin
            if (take) begin
               rem_ff <= DEN_W'(trial - {1'b0, den_ff});
            end else begin
               rem_ff <= trial[DEN_W-1:0];
            end
            lo_ff   <= {lo_ff[QUOT_W-2:0], take};
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = lo_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/glue_ratio_fixed_point_setup.sv
// Glue ratio setup for fixed-point glue setting. Each request word carries a
// positive glue sum s, a target total t and the largest glue magnitude y; the
// response word gives the shift code a+16, the post shift b and the multiplier
// c, so that ((x >> a) * c) >> b approximates x*t/s, together with a flag that
// is raised when b would be negative and the glue would grow too large. An
// input of zero is taken as one. A word passes through normalization, which
// halves the shift at each step, then, unless the ratio is out of range,
// through the shared restoring divider, which yields one quotient bit per
// cycle, and for large sums through one multiply, one remainder step and up
// to eight correction steps. The block holds one word at a time and accepts
// a new request once it has handed its result to the response register,
// even while that response still waits.
module glue_ratio_fixed_point_setup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  grfps_pkg::operand_type req_glue_sum,
   input  grfps_pkg::operand_type req_target_total,
   input  grfps_pkg::operand_type req_max_magnitude,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_pre_shift_code,
   output logic [4:0]             rsp_post_shift,
   output logic [15:0]            rsp_multiplier,
   output logic                   rsp_excessive
);
   import grfps_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_EXP,
      ST_SMALL,
      ST_DIVSTART,
      ST_DIV,
      ST_MUL,
      ST_REM,
      ST_ROUND_UP,
      ST_CORR,
      ST_FIN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [2:0]         step_ff;
   operand_type        s0_ff, sn_ff, tn_ff, yn_ff;
   count_type          ns_ff, nt_ff, ny_ff;
   logic               below_ff;
   logic               small_ff;
   logic [4:0]         l_ff;
   logic [4:0]         b_ff;
   logic [15:0]        c_ff;
   logic               excess_ff;
   operand_type        div_num_ff;
   divisor_type        div_den_ff;
   logic [17:0]        q_ff;
   divisor_type        rem_ff;
   logic [32:0]        prod_ff;
   logic signed [35:0] r_ff;
   logic [3:0]         cnt_ff;

   logic               rsp_valid_ff;
   logic [4:0]         rsp_pre_ff, rsp_post_ff;
   logic [15:0]        rsp_mult_ff;
   logic               rsp_exc_ff;

   logic               div_done;
   quotient_type       div_quot;
   divisor_type        div_rem;

   // One halving step of the normalizer: shift left by amt when the top amt
   // bits are all clear.
   function automatic operand_type norm_shift(input operand_type x, input logic [2:0] step);
      operand_type r;
      r = x;
      unique case (step)
         3'd0: if (x[30:15] == '0) r = {x[14:0], 16'd0};
         3'd1: if (x[30:23] == '0) r = {x[22:0], 8'd0};
         3'd2: if (x[30:27] == '0) r = {x[26:0], 4'd0};
         3'd3: if (x[30:29] == '0) r = {x[28:0], 2'd0};
         default: if (!x[30]) r = {x[29:0], 1'b0};
      endcase
      return r;
   endfunction

   function automatic count_type norm_count(input operand_type x, input logic [2:0] step,
                                            input count_type n);
      count_type r;
      r = n;
      unique case (step)
         3'd0: if (x[30:15] == '0) r = n + 5'd16;
         3'd1: if (x[30:23] == '0) r = n + 5'd8;
         3'd2: if (x[30:27] == '0) r = n + 5'd4;
         3'd3: if (x[30:29] == '0) r = n + 5'd2;
         default: if (!x[30]) r = n + 5'd1;
      endcase
      return r;
   endfunction

   // Exponent arithmetic. The post shift b is (15 or 14) - a - k + h with
   // a = 15 - ny, so the constant term is 0 when t < s and -1 otherwise.
   logic               below_in;
   logic signed [7:0]  b_calc;
   logic [4:0]         sh_small;
   logic [4:0]         l_calc;
   operand_type        num_small;
   logic signed [35:0] r_sum;
   logic               r_low;
   logic [17:0]        c_round;

   assign below_in = tn_ff < sn_ff;
   assign b_calc   = $signed({3'b000, ny_ff}) - $signed({3'b000, ns_ff})
                   + $signed({3'b000, nt_ff}) - (below_in ? 8'sd0 : 8'sd1);
   assign l_calc   = 5'd16 - ns_ff;

   // Direct path for small sums: ceil((t >> sh) / s) with sh = k - 15 or k - 14.
   assign sh_small  = ns_ff - (below_ff ? 5'd15 : 5'd14);
   assign num_small = (tn_ff >> sh_small) + s0_ff - 31'd1;

   // Remainder correction: step down while r + s stays at or below zero.
   assign r_sum = r_ff + $signed({5'b00000, s0_ff});
   assign r_low = r_sum[35] || (r_sum == '0);

   // Final rounding of the long-division quotient to the multiplier.
   assign c_round = below_ff ? ((q_ff + 18'd1) >> 1) : ((q_ff + 18'd3) >> 2);

   grfps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_DIVSTART),
      .dividend  (div_num_ff),
      .divisor   (div_den_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the hand-over state the response register is refilled instead.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  // A zero operand behaves as one.
                  s0_ff   <= (req_glue_sum == '0) ? 31'd1 : req_glue_sum;
                  sn_ff   <= (req_glue_sum == '0) ? 31'd1 : req_glue_sum;
                  tn_ff   <= (req_target_total == '0) ? 31'd1 : req_target_total;
                  yn_ff   <= (req_max_magnitude == '0) ? 31'd1 : req_max_magnitude;
                  ns_ff   <= '0;
                  nt_ff   <= '0;
                  ny_ff   <= '0;
                  step_ff <= '0;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               sn_ff <= norm_shift(sn_ff, step_ff);
               tn_ff <= norm_shift(tn_ff, step_ff);
               yn_ff <= norm_shift(yn_ff, step_ff);
               ns_ff <= norm_count(sn_ff, step_ff, ns_ff);
               nt_ff <= norm_count(tn_ff, step_ff, nt_ff);
               ny_ff <= norm_count(yn_ff, step_ff, ny_ff);
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'(NORM_STEPS - 1)) begin
                  state_ff <= ST_EXP;
               end
            end
            ST_EXP: begin
               below_ff  <= below_in;
               excess_ff <= 1'b0;
               l_ff      <= l_calc;
               if (b_calc < 8'sd0) begin
                  excess_ff <= 1'b1;
                  b_ff      <= '0;
                  c_ff      <= '0;
                  state_ff  <= ST_DONE;
               end else if (b_calc > 8'sd30) begin
                  b_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= ST_DONE;
               end else if (ns_ff >= SMALL_SUM_CNT) begin
                  b_ff     <= b_calc[4:0];
                  small_ff <= 1'b1;
                  state_ff <= ST_SMALL;
               end else begin
                  // Long division of t by the top 15 bits of s.
                  b_ff       <= b_calc[4:0];
                  small_ff   <= 1'b0;
                  div_num_ff <= tn_ff;
                  div_den_ff <= DEN_W'(s0_ff >> l_calc);
                  state_ff   <= ST_DIVSTART;
               end
            end
            ST_SMALL: begin
               div_num_ff <= num_small;
               div_den_ff <= s0_ff[DEN_W-1:0];
               state_ff   <= ST_DIVSTART;
            end
            ST_DIVSTART: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  if (small_ff) begin
                     c_ff     <= div_quot[15:0];
                     state_ff <= ST_DONE;
                  end else begin
                     q_ff     <= {1'b0, div_quot};
                     rem_ff   <= div_rem;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               // The low l bits of s that the divisor left out, times q.
               prod_ff  <= {17'd0, 16'(s0_ff & ((31'd1 << l_ff) - 31'd1))}
                         * {16'd0, q_ff[QUOT_W-1:0]};
               state_ff <= ST_REM;
            end
            ST_REM: begin
               r_ff     <= $signed({5'b00000, 31'(rem_ff) << l_ff})
                         - $signed({3'b000, prod_ff});
               cnt_ff   <= '0;
               state_ff <= ST_ROUND_UP;
            end
            ST_ROUND_UP: begin
               if (r_ff > 36'sd0) begin
                  q_ff     <= q_ff + 18'd1;
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_CORR;
               end
            end
            ST_CORR: begin
               if ((cnt_ff < 4'(CORR_MAX)) && r_low) begin
                  q_ff   <= q_ff - 18'd1;
                  r_ff   <= r_sum;
                  cnt_ff <= cnt_ff + 4'd1;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               c_ff     <= c_round[15:0];
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // Hand the word over once the response register is free.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pre_ff   <= 5'd31 - ny_ff;
                  rsp_post_ff  <= b_ff;
                  rsp_mult_ff  <= c_ff;
                  rsp_exc_ff   <= excess_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pre_shift_code = rsp_pre_ff;
   assign rsp_post_shift     = rsp_post_ff;
   assign rsp_multiplier     = rsp_mult_ff;
   assign rsp_excessive      = rsp_exc_ff;

endmodule

>>> dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import grfps_pkg::*;

   // One response word: the four fields in port order.
   typedef struct packed {
      logic [4:0]  pre_shift_code;
      logic [4:0]  post_shift;
      logic [15:0] multiplier;
      logic        excessive;
   } ratio_word_t;

   // A directed row carries its operands and, where the answer is obvious from the
   // ranges alone, a typed-in response. Otherwise the predictor supplies it.
   typedef struct {
      operand_type glue_sum;
      operand_type target_total;
      operand_type max_magnitude;
      bit          typed;
      ratio_word_t want;
   } ratio_row_t;

   localparam int NUM_ROWS = 18;
   localparam int RANDOM_PER_PHASE = 533;
   // Cycles without any handshake before the run is declared hung. The receiver's
   // stalls are short random runs, so this leaves a wide margin.
   localparam int HANG_LIMIT = 2000;
   // Cycles to watch after the last response for any stray word.
   localparam int TAIL_CYCLES = 60;
   localparam operand_type ALL_ONES = 31'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   operand_type req_glue_sum = '0;
   operand_type req_target_total = '0;
   operand_type req_max_magnitude = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_pre_shift_code;
   logic [4:0]  rsp_post_shift;
   logic [15:0] rsp_multiplier;
   logic        rsp_excessive;

   // Responses still owed by the block, oldest first.
   ratio_word_t pending_ratios[$];
   int          mismatch_count = 0;
   int          hang_cycles = 0;
   // Percentages of cycles in which the sender and the receiver hold back.
   int          send_idle_pct = 12;
   int          recv_idle_pct = 58;

   ratio_row_t  dir_rows[NUM_ROWS];

   always #4 clock = ~clock;

   glue_ratio_fixed_point_setup uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_glue_sum       (req_glue_sum),
      .req_target_total   (req_target_total),
      .req_max_magnitude  (req_max_magnitude),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pre_shift_code (rsp_pre_shift_code),
      .rsp_post_shift     (rsp_post_shift),
      .rsp_multiplier     (rsp_multiplier),
      .rsp_excessive      (rsp_excessive)
   );

   // Number of doublings that bring an operand up to bit 30. A zero operand is
   // taken as one, exactly as the block does.
   function automatic int lead_doublings(input operand_type v);
      operand_type x;
      int          n;
      x = (v == '0) ? 31'd1 : v;
      n = 0;
      while (!x[30] && n < 30) begin
         x = x << 1;
         n++;
      end
      return n;
   endfunction

   // Works out the shift code, post shift, multiplier and flag for one request.
   // The normalized s and t are held in 64-bit signed variables so that the
   // remainder of the long division may go negative without wrapping.
   function automatic ratio_word_t predict_ratio(input operand_type s_in,
                                                 input operand_type t_in,
                                                 input operand_type y_in);
      longint      s0, s_n, t_n, num, q, r, w, s1, mult;
      int          a, k, h, b, sh, l, steps;
      bit          below, excess;
      ratio_word_t res;
      s0 = (s_in == '0) ? 1 : longint'(s_in);
      a = 15 - lead_doublings(y_in);
      k = lead_doublings(s_in);
      h = lead_doublings(t_in);
      s_n = s0 << k;
      t_n = ((t_in == '0) ? 1 : longint'(t_in)) << h;
      below = t_n < s_n;
      b = (below ? 15 : 14) - a - k + h;
      excess = 1'b0;
      mult = 0;
      if (b < 0 || b > 30) begin
         // Ratio unusable: the flag only marks the case where b fell below zero.
         excess = b < 0;
         b = 0;
      end else if (k >= 16) begin
         // Small sum: a plain ceiling division by the original s.
         sh = h - a - b;
         if (sh < 0) sh = 0;
         if (sh > 31) sh = 31;
         num = (t_n >> sh) + s0 - 1;
         mult = num / s0;
      end else begin
         // Large sum: divide by the top 15 bits of s, then settle the quotient
         // against the bits of s that were dropped.
         l = 16 - k;
         w = longint'(1) << l;
         s1 = s0 >> l;
         if (s1 == 0) s1 = 1;
         q = t_n / s1;
         r = (t_n % s1) * w - (s0 & (w - 1)) * q;
         if (r > 0) begin
            q++;
            r -= s0;
         end else begin
            for (steps = 0; steps < 8 && r <= -s0; steps++) begin
               q--;
               r += s0;
            end
         end
         if (q < 0) q = 0;
         mult = below ? (q + 1) / 2 : (q + 3) / 4;
      end
      res.pre_shift_code = 5'(a + 16);
      res.post_shift     = 5'(b);
      res.multiplier     = 16'(mult);
      res.excessive      = excess;
      return res;
   endfunction

   // An operand whose leading one sits at bit position lead, lower bits random.
   function automatic operand_type operand_at(input int lead);
      operand_type top;
      top = operand_type'(1) << lead;
      return top | (operand_type'($urandom) & (top - 1));
   endfunction

   // Unshaped operand: zero, all ones, or random bits with a random leading run of
   // zeros.
   function automatic operand_type noise_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return ALL_ONES;
         default: return operand_type'($urandom) >> $urandom_range(30);
      endcase
   endfunction

   // Presents one request word, after a random number of idle cycles, and holds
   // it until the block takes it. Valid is left high on return so that a word
   // that follows straight on needs no lowering in between.
   task automatic send_word(input operand_type s, input operand_type t,
                            input operand_type y, input ratio_word_t want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_glue_sum      <= s;
      req_target_total  <= t;
      req_max_magnitude <= y;
      do @(posedge clock); while (!req_ready);
      pending_ratios.push_back(want);
   endtask

   // Holds the sender back until every owed response has come out.
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_ratios.size() != 0);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // The receiver decides afresh at every edge whether it will take a word.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Response checker and hang watchdog. Every accepted response word is matched
   // against the oldest expectation; a word with nothing owed is itself an error.
   always @(posedge clock) begin
      ratio_word_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ratios.size() == 0) begin
            $display("%0t: response word with none expected, actual %0d %0d %0d %0d",
                     $time, rsp_pre_shift_code, rsp_post_shift, rsp_multiplier,
                     rsp_excessive);
            mismatch_count++;
         end else begin
            want = pending_ratios.pop_front();
            check_field("pre_shift_code", want.pre_shift_code, rsp_pre_shift_code);
            check_field("post_shift", want.post_shift, rsp_post_shift);
            check_field("multiplier", want.multiplier, rsp_multiplier);
            check_field("excessive", want.excessive, rsp_excessive);
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         hang_cycles <= 0;
      else
         hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int          i, phase, es, ey, et, bt;
      operand_type s, t, y;
      ratio_word_t want;

      // Directed words. The typed-in rows are the unusable ratios, whose answer
      // follows from the exponents alone: a sum of one against full-scale t
      // drives b far below zero, and a full-scale sum against t of one drives it
      // far above thirty. Everything else goes through the predictor.
      dir_rows = '{
         '{31'd1, 31'd1, 31'd1, 1'b0, '0},
         '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, '0},
         '{31'd0, 31'd0, 31'd0, 1'b0, '0},
         '{31'd0, 31'd5, 31'd100, 1'b0, '0},
         '{31'd1, ALL_ONES, ALL_ONES, 1'b1, '{5'd31, 5'd0, 16'd0, 1'b1}},
         '{31'd1, 31'h4000_0000, 31'h4000_0000, 1'b1, '{5'd31, 5'd0, 16'd0, 1'b1}},
         '{31'd1, ALL_ONES, 31'h0010_0000, 1'b1, '{5'd21, 5'd0, 16'd0, 1'b1}},
         '{ALL_ONES, 31'd1, 31'd1, 1'b1, '{5'd1, 5'd0, 16'd0, 1'b0}},
         '{ALL_ONES, 31'd1, 31'h0000_0400, 1'b1, '{5'd11, 5'd0, 16'd0, 1'b0}},
         '{31'h0000_7FFF, 31'h0123_4567, 31'h0000_8000, 1'b0, '0},
         '{31'h0000_8000, 31'h0123_4567, 31'h0000_8000, 1'b0, '0},
         '{31'h0000_8001, ALL_ONES, 31'h0001_0000, 1'b0, '0},
         '{31'h4000_0000, 31'h3FFF_FFFF, 31'h0010_0000, 1'b0, '0},
         '{31'h4000_0000, 31'h4000_0000, 31'h0010_0000, 1'b0, '0},
         '{31'd3, 31'd7, 31'd1000, 1'b0, '0},
         '{31'd12345678, 31'd87654321, 31'd4096, 1'b0, '0},
         '{31'h2AAA_AAAA, 31'h5555_5555, 31'h0000_FFFF, 1'b0, '0},
         '{31'h0000_4321, 31'h0000_4321, 31'h0000_0007, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         want = dir_rows[i].typed ? dir_rows[i].want :
                predict_ratio(dir_rows[i].glue_sum, dir_rows[i].target_total,
                              dir_rows[i].max_magnitude);
         send_word(dir_rows[i].glue_sum, dir_rows[i].target_total,
                   dir_rows[i].max_magnitude, want);
      end
      drain_block();

      // Random words in three idling phases: a slow receiver, then a slow sender,
      // then both flat out. Most words are shaped so that b lands inside its usable
      // range, by choosing the exponent of t from those of s and y and a target b;
      // the rest are unshaped noise that mostly hits the unusable cases.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 58 : 0;
         recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 12 : 0;
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            if ($urandom_range(4) != 0) begin
               es = $urandom_range(30);
               ey = $urandom_range(30);
               bt = $urandom_range(30);
               et = 29 - ey + es - bt;
               if (et < 0) et = 0;
               if (et > 30) et = 30;
               s = operand_at(es);
               t = operand_at(et);
               y = operand_at(ey);
            end else begin
               s = noise_operand();
               t = noise_operand();
               y = noise_operand();
            end
            send_word(s, t, y, predict_ratio(s, t, y));
            // Now and then let the block run completely dry before going on.
            if (i % 200 == 199)
               drain_block();
         end
      end

      drain_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
